### rtl/lfr_pkg.sv
`timescale 1ns / 1ps
// Shared types, frame constants and the CRC-16/MODBUS byte update for the lidar frame receiver.
// Used by every module of the block; depends on nothing.
package lfr_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] HDR_SYNC = 8'hA5;
    localparam logic [7:0] HDR_DEV = 8'h03;
    localparam logic [7:0] HDR_TYPE = 8'h20;
    localparam logic [7:0] HDR_ZERO = 8'h00;
    localparam logic [7:0] CMD_STREAM = 8'h01;
    localparam logic [7:0] MAX_LEN = 8'h0E;
    localparam logic [3:0] FULL_LEN = 4'hE;

    localparam logic [4:0] POS_SYNC = 5'd0;
    localparam logic [4:0] POS_DEV = 5'd1;
    localparam logic [4:0] POS_TYPE = 5'd2;
    localparam logic [4:0] POS_CMD = 5'd3;
    localparam logic [4:0] POS_PAD0 = 5'd4;
    localparam logic [4:0] POS_PAD1 = 5'd5;
    localparam logic [4:0] POS_LEN = 5'd6;
    localparam logic [4:0] POS_DATA = 5'd7;
    localparam logic [4:0] POS_DATA_LAST = 5'd20;
    localparam logic [4:0] POS_CRCH = 5'd21;
    localparam logic [4:0] POS_CRCL = 5'd22;
    localparam logic [4:0] LAST_OFS = 5'd8;

    localparam int DATA_BYTES = 14;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] STATUS_VALID = 2'd0;
    localparam logic [1:0] STATUS_BAD_CMD = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;
    localparam logic [1:0] STATUS_BAD_CRC = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic [4:0] pos;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [1:0]         frame_status;
        logic signed [15:0] primary_distance_mm;
        logic [15:0]        primary_correction;
        logic [15:0]        primary_intensity;
        logic signed [15:0] secondary_distance_mm;
        logic [15:0]        secondary_correction;
        logic [15:0]        secondary_intensity;
        logic [15:0]        sunlight_base;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/lidar_frame_receiver_crc16_top.sv
`timescale 1ns / 1ps
// Lidar frame receiver: one serial byte per beat in, one status and data result per frame out.
// Throughput is one byte per cycle while full is low, set by the combinational CRC byte update in the back end.
// A frame's last byte enters the beat queue when it is accepted and reaches the result register once the
// beats ahead of it have left the queue, unless a result still waits.
// Reset returns the frame position to sync, loads the CRC with CRC_INIT, empties the queues and sets crc_en_reg to 1.
// Depends on lfr_pkg, lfr_front, lfr_fifo and lfr_back.
module lidar_frame_receiver_crc16_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         frame_status,
    output logic signed [15:0] primary_distance_mm,
    output logic [15:0]        primary_correction,
    output logic [15:0]        primary_intensity,
    output logic signed [15:0] secondary_distance_mm,
    output logic [15:0]        secondary_correction,
    output logic [15:0]        secondary_intensity,
    output logic [15:0]        sunlight_base,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import lfr_pkg::*;

    logic    crc_en_reg;
    logic    f_push;
    beat_t   f_beat;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    beat_t   q_beat;
    result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_en_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            crc_en_reg <= cfg_data;
        end
    end

    lfr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rx_byte (rx_byte),
        .full    (full),
        .q_full  (q_full),
        .q_push  (f_push),
        .q_beat  (f_beat)
    );

    lfr_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_beat (f_beat),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_beat (q_beat),
        .empty   (q_empty)
    );

    lfr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .crc_en  (crc_en_reg),
        .q_empty (q_empty),
        .q_beat  (q_beat),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    assign frame_status = result.frame_status;
    assign primary_distance_mm = result.primary_distance_mm;
    assign primary_correction = result.primary_correction;
    assign primary_intensity = result.primary_intensity;
    assign secondary_distance_mm = result.secondary_distance_mm;
    assign secondary_correction = result.secondary_correction;
    assign secondary_intensity = result.secondary_intensity;
    assign sunlight_base = result.sunlight_base;

endmodule

### rtl/lfr_front.sv
`timescale 1ns / 1ps
// Front end: tracks the frame position, checks the header and length bytes, and queues
// accepted bytes that pass the checks, tagged with their position. Depends on lfr_pkg.
module lfr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [7:0]    rx_byte,
    output logic          full,
    input  logic          q_full,
    output logic          q_push,
    output lfr_pkg::beat_t q_beat
);
    import lfr_pkg::*;

    logic [4:0] pos_reg;
    logic [4:0] pos_next;
    logic [3:0] len_reg;
    logic [3:0] len_next;
    logic       accept;
    logic       bad;
    logic       last;

    assign full = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        case (pos_reg)
            POS_SYNC: bad = (rx_byte != HDR_SYNC);
            POS_DEV: bad = (rx_byte != HDR_DEV);
            POS_TYPE: bad = (rx_byte != HDR_TYPE);
            POS_PAD0, POS_PAD1: bad = (rx_byte != HDR_ZERO);
            POS_LEN: bad = (rx_byte > MAX_LEN);
            default: bad = 1'b0;
        endcase
    end

    assign last = (pos_reg >= POS_DATA) && (pos_reg == ({1'b0, len_reg} + LAST_OFS));

    always_comb
    begin
        pos_next = pos_reg;
        len_next = len_reg;
        if (accept)
        begin
            if (bad || last)
            begin
                pos_next = POS_SYNC;
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
            end
            if (!bad && pos_reg == POS_LEN)
            begin
                len_next = rx_byte[3:0];
            end
        end
    end

    assign q_push = accept && !bad;
    assign q_beat = '{data: rx_byte, pos: pos_reg, last: last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_SYNC;
            len_reg <= 4'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

endmodule

### rtl/lfr_fifo.sv
`timescale 1ns / 1ps
// Short queue of classified byte beats between the front end and the back end.
// Depends on lfr_pkg for the beat type and depth.
module lfr_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  lfr_pkg::beat_t wr_beat,
    output logic           full,
    input  logic           rd_en,
    output lfr_pkg::beat_t rd_beat,
    output logic           empty
);
    import lfr_pkg::*;

    beat_t                 slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg;
    logic [FIFO_AW-1:0]    rd_ptr_reg;
    logic [FIFO_CW-1:0]    count_reg;
    logic [FIFO_CW-1:0]    count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign full = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_beat = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

### rtl/lfr_back.sv
`timescale 1ns / 1ps
// Back end: runs the CRC over queued beats, keeps the frame bytes, and on the last beat
// builds the status and data fields into the result register. Depends on lfr_pkg.
module lfr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             crc_en,
    input  logic             q_empty,
    input  lfr_pkg::beat_t   q_beat,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output lfr_pkg::result_t result
);
    import lfr_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_base;
    logic [7:0]  cmd_reg;
    logic [7:0]  crch_reg;
    logic [7:0]  data_reg [DATA_BYTES];
    logic [4:0]  data_ofs;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        fire;
    logic [1:0]  status;
    result_t     result_reg;
    result_t     result_next;

    assign fire = !q_empty && (!q_beat.last || !out_valid_reg || pop);
    assign q_pop = fire;
    assign empty = !out_valid_reg;
    assign result = result_reg;
    assign data_ofs = q_beat.pos - POS_DATA;

    assign crc_base = (q_beat.pos == POS_SYNC) ? CRC_INIT : crc_reg;

    always_comb
    begin
        crc_next = crc_reg;
        if (fire && q_beat.pos < POS_CRCH)
        begin
            crc_next = crc_byte(crc_base, q_beat.data);
        end
    end

    always_comb
    begin
        if (cmd_reg != CMD_STREAM)
        begin
            status = STATUS_BAD_CMD;
        end
        else if (q_beat.pos != POS_CRCL)
        begin
            status = STATUS_BAD_LEN;
        end
        else if (crc_en && crc_reg != {crch_reg, q_beat.data})
        begin
            status = STATUS_BAD_CRC;
        end
        else
        begin
            status = STATUS_VALID;
        end
    end

    always_comb
    begin
        result_next = '0;
        result_next.frame_status = status;
        if (status == STATUS_VALID)
        begin
            result_next.secondary_distance_mm = {data_reg[1], data_reg[0]};
            result_next.secondary_correction = {data_reg[3], data_reg[2]};
            result_next.secondary_intensity = {data_reg[5], data_reg[4]};
            result_next.primary_distance_mm = {data_reg[7], data_reg[6]};
            result_next.primary_correction = {data_reg[9], data_reg[8]};
            result_next.primary_intensity = {data_reg[11], data_reg[10]};
            result_next.sunlight_base = {data_reg[13], data_reg[12]};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && q_beat.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (q_beat.pos == POS_CMD)
            begin
                cmd_reg <= q_beat.data;
            end
            if (q_beat.pos == POS_CRCH)
            begin
                crch_reg <= q_beat.data;
            end
            if (q_beat.pos >= POS_DATA && q_beat.pos <= POS_DATA_LAST)
            begin
                data_reg[data_ofs[3:0]] <= q_beat.data;
            end
            if (q_beat.last)
            begin
                result_reg <= result_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### sim/tb_lidar_frame_receiver_crc16_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for lidar_frame_receiver_crc16_top: it drives the byte stream, predicts
// each frame result, and checks every result beat field by field.
// Depends on lfr_pkg and the receiver RTL.
module tb_lidar_frame_receiver_crc16_top;

    import lfr_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int FRAME_LEN = 23;
    localparam int CRC_SPAN = 21;
    localparam int NO_CORRUPT = -1;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BYTES = 700;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MIN, FILL_MAX} fill_e;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [7:0]         rx_byte;
    logic               empty;
    logic               pop;
    logic [1:0]         frame_status;
    logic signed [15:0] primary_distance_mm;
    logic [15:0]        primary_correction;
    logic [15:0]        primary_intensity;
    logic signed [15:0] secondary_distance_mm;
    logic [15:0]        secondary_correction;
    logic [15:0]        secondary_intensity;
    logic [15:0]        sunlight_base;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;

    logic [4:0]  frame_pos;
    logic [3:0]  frame_len;
    logic [15:0] frame_crc;
    logic [7:0]  frame_bytes [0:FRAME_LEN-1];
    logic        crc_enabled;

    result_t     results_due [$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          hold_request = 1'b0;

    lidar_frame_receiver_crc16_top i_dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .push                  (push),
        .full                  (full),
        .rx_byte               (rx_byte),
        .empty                 (empty),
        .pop                   (pop),
        .frame_status          (frame_status),
        .primary_distance_mm   (primary_distance_mm),
        .primary_correction    (primary_correction),
        .primary_intensity     (primary_intensity),
        .secondary_distance_mm (secondary_distance_mm),
        .secondary_correction  (secondary_correction),
        .secondary_intensity   (secondary_intensity),
        .sunlight_base         (sunlight_base),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_data              (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] v;
        v = acc ^ {8'h00, b};
        repeat (8)
        begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    function automatic logic [15:0] data_word(input int ofs);
        return {frame_bytes[POS_DATA + ofs + 1], frame_bytes[POS_DATA + ofs]};
    endfunction

    task automatic restart_frame();
        frame_pos = POS_SYNC;
        frame_crc = CRC_INIT;
    endtask

    task automatic predict_byte(input logic [7:0] b);
        int      p;
        bit      drop;
        result_t r;
        p = int'(frame_pos);
        drop = 1'b0;
        if (p >= FRAME_LEN)
        begin
            p = 0;
        end
        frame_bytes[p] = b;
        case (p)
            POS_SYNC: drop = (b != HDR_SYNC);
            POS_DEV:  drop = (b != HDR_DEV);
            POS_TYPE: drop = (b != HDR_TYPE);
            POS_PAD0, POS_PAD1: drop = (b != HDR_ZERO);
            POS_LEN:
            begin
                if (b > MAX_LEN)
                begin
                    drop = 1'b1;
                end
                else
                begin
                    frame_len = b[3:0];
                end
            end
            default: drop = 1'b0;
        endcase
        if (drop)
        begin
            restart_frame();
            return;
        end
        if (p < CRC_SPAN)
        begin
            frame_crc = modbus_crc_step(frame_crc, b);
        end
        frame_pos = 5'(p + 1);
        if (p < POS_DATA || p + 1 != int'(frame_len) + 9)
        begin
            return;
        end
        r = '0;
        if (frame_bytes[POS_CMD] != CMD_STREAM)
        begin
            r.frame_status = STATUS_BAD_CMD;
        end
        else if (frame_len != FULL_LEN)
        begin
            r.frame_status = STATUS_BAD_LEN;
        end
        else if (crc_enabled && frame_crc != {frame_bytes[POS_CRCH], frame_bytes[POS_CRCL]})
        begin
            r.frame_status = STATUS_BAD_CRC;
        end
        else
        begin
            r.frame_status = STATUS_VALID;
            r.primary_distance_mm = data_word(6);
            r.primary_correction = data_word(8);
            r.primary_intensity = data_word(10);
            r.secondary_distance_mm = data_word(0);
            r.secondary_correction = data_word(2);
            r.secondary_intensity = data_word(4);
            r.sunlight_base = data_word(12);
        end
        results_due.push_back(r);
        restart_frame();
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        result_t e;
        if (results_due.size() == 0)
        begin
            report_mismatch("result beat with no frame pending", 16'(frame_status), 16'd0);
            return;
        end
        e = results_due.pop_front();
        if (frame_status !== e.frame_status)
            report_mismatch("frame_status", 16'(frame_status), 16'(e.frame_status));
        if (primary_distance_mm !== e.primary_distance_mm)
            report_mismatch("primary_distance_mm", primary_distance_mm, e.primary_distance_mm);
        if (primary_correction !== e.primary_correction)
            report_mismatch("primary_correction", primary_correction, e.primary_correction);
        if (primary_intensity !== e.primary_intensity)
            report_mismatch("primary_intensity", primary_intensity, e.primary_intensity);
        if (secondary_distance_mm !== e.secondary_distance_mm)
            report_mismatch("secondary_distance_mm", secondary_distance_mm,
                            e.secondary_distance_mm);
        if (secondary_correction !== e.secondary_correction)
            report_mismatch("secondary_correction", secondary_correction,
                            e.secondary_correction);
        if (secondary_intensity !== e.secondary_intensity)
            report_mismatch("secondary_intensity", secondary_intensity, e.secondary_intensity);
        if (sunlight_base !== e.sunlight_base)
            report_mismatch("sunlight_base", sunlight_base, e.sunlight_base);
    endtask

    // The result side: accepts beats, checks them, and stalls in random bursts while rx_idle is set, or on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                check_result();
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (full);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input bit bad_crc,
                              input fill_e fill, input int corrupt_at);
        logic [7:0]  fb [0:FRAME_LEN-1];
        logic [15:0] c;
        int          n_data;
        int          n;
        fb[POS_SYNC] = HDR_SYNC;
        fb[POS_DEV] = HDR_DEV;
        fb[POS_TYPE] = HDR_TYPE;
        fb[POS_CMD] = cmd;
        fb[POS_PAD0] = HDR_ZERO;
        fb[POS_PAD1] = HDR_ZERO;
        fb[POS_LEN] = len;
        n_data = (len <= MAX_LEN) ? int'(len) : DATA_BYTES;
        for (int i = 0; i < n_data; i++)
        begin
            case (fill)
                FILL_ZERO: fb[POS_DATA + i] = 8'h00;
                FILL_ONES: fb[POS_DATA + i] = 8'hFF;
                FILL_MIN:  fb[POS_DATA + i] = (i % 2) ? 8'h80 : 8'h00;
                FILL_MAX:  fb[POS_DATA + i] = (i % 2) ? 8'h7F : 8'hFF;
                default:   fb[POS_DATA + i] = 8'($urandom);
            endcase
        end
        n = POS_DATA + n_data + 2;
        c = CRC_INIT;
        for (int i = 0; i < n - 2; i++)
        begin
            c = modbus_crc_step(c, fb[i]);
        end
        fb[n - 2] = c[15:8];
        fb[n - 1] = c[7:0];
        if (bad_crc)
        begin
            fb[n - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        end
        if (corrupt_at != NO_CORRUPT)
        begin
            fb[corrupt_at] ^= 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < n; i++)
        begin
            send_byte(fb[i]);
        end
    endtask

    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_byte(8'($urandom));
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_crc_check(input logic en);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= en;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        crc_enabled = en;
    endtask

    task automatic test_valid_frames();
        send_frame(CMD_STREAM, MAX_LEN, 1'b0, FILL_ZERO, NO_CORRUPT);
        send_frame(CMD_STREAM, MAX_LEN, 1'b0, FILL_ONES, NO_CORRUPT);
        send_frame(CMD_STREAM, MAX_LEN, 1'b0, FILL_MIN, NO_CORRUPT);
        send_frame(CMD_STREAM, MAX_LEN, 1'b0, FILL_MAX, NO_CORRUPT);
    endtask

    task automatic test_bad_command();
        send_frame(8'h00, MAX_LEN, 1'b0, FILL_RANDOM, NO_CORRUPT);
        send_frame(8'hFF, 8'h03, 1'b0, FILL_RANDOM, NO_CORRUPT);
    endtask

    task automatic test_short_frames();
        send_frame(CMD_STREAM, 8'h00, 1'b0, FILL_RANDOM, NO_CORRUPT);
        send_frame(CMD_STREAM, 8'h0D, 1'b0, FILL_RANDOM, NO_CORRUPT);
        send_frame(CMD_STREAM, 8'h0F, 1'b0, FILL_ZERO, NO_CORRUPT);
        send_frame(CMD_STREAM, 8'hFF, 1'b0, FILL_ZERO, NO_CORRUPT);
        send_frame(CMD_STREAM, MAX_LEN, 1'b0, FILL_RANDOM, NO_CORRUPT);
    endtask

    task automatic test_header_resync();
        send_byte(HDR_SYNC);
        send_frame(CMD_STREAM, MAX_LEN, 1'b0, FILL_ZERO, NO_CORRUPT);
        for (int k = POS_SYNC; k <= POS_LEN; k++)
        begin
            send_frame(CMD_STREAM, MAX_LEN, 1'b0, FILL_ZERO, k);
        end
        send_frame(CMD_STREAM, MAX_LEN, 1'b0, FILL_RANDOM, NO_CORRUPT);
    endtask

    task automatic test_crc_check();
        send_frame(CMD_STREAM, MAX_LEN, 1'b1, FILL_RANDOM, NO_CORRUPT);
        set_crc_check(1'b0);
        send_frame(CMD_STREAM, MAX_LEN, 1'b1, FILL_RANDOM, NO_CORRUPT);
        send_frame(CMD_STREAM, MAX_LEN, 1'b0, FILL_RANDOM, NO_CORRUPT);
        send_frame(8'h02, MAX_LEN, 1'b1, FILL_RANDOM, NO_CORRUPT);
        set_crc_check(1'b1);
        send_frame(CMD_STREAM, MAX_LEN, 1'b1, FILL_ONES, NO_CORRUPT);
    endtask

    task automatic test_input_stall();
        wait_idle();
        tx_idle = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 20; i++)
        begin
            send_frame(CMD_STREAM, MAX_LEN, $urandom_range(0, 7) == 0, FILL_RANDOM, NO_CORRUPT);
        end
        tx_idle = 1'b1;
    endtask

    task automatic send_random_item();
        int          kind;
        logic [7:0]  cmd;
        logic [7:0]  len;
        kind = $urandom_range(0, 99);
        cmd = ($urandom_range(0, 4) == 0) ? 8'($urandom) : CMD_STREAM;
        len = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 13)) : MAX_LEN;
        if (kind < 72)
        begin
            send_frame(cmd, len, $urandom_range(0, 5) == 0, FILL_RANDOM, NO_CORRUPT);
        end
        else if (kind < 82)
        begin
            send_noise($urandom_range(1, 8));
        end
        else if (kind < 90)
        begin
            send_frame(cmd, 8'($urandom), $urandom_range(0, 1) == 1, FILL_RANDOM, NO_CORRUPT);
        end
        else
        begin
            send_frame(cmd, len, 1'b0, FILL_RANDOM, int'($urandom_range(POS_SYNC, POS_LEN)));
        end
    endtask

    task automatic test_random_stream();
        int target;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
        begin
            set_crc_check($urandom_range(0, 1) == 1);
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            for (int i = 0; i < 20; i++)
            begin
                send_random_item();
            end
        end
        set_crc_check(1'b1);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_full_rate();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int i = 0; i < 15; i++)
        begin
            send_random_item();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        rx_byte = 8'h00;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        crc_enabled = 1'b1;
        frame_len = '0;
        restart_frame();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_valid_frames();
        test_bad_command();
        test_short_frames();
        test_header_resync();
        test_crc_check();
        test_input_stall();
        test_random_stream();
        test_full_rate();
        wait_idle();
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/lfr_pkg.sv
rtl/lfr_front.sv
rtl/lfr_fifo.sv
rtl/lfr_back.sv
rtl/lidar_frame_receiver_crc16_top.sv
sim/tb_lidar_frame_receiver_crc16_top.sv
